// ===== hw/rtl/bsa_pkg.sv =====
`default_nettype none

package bsa_pkg;

    // slots per map row, scanned one row a cycle
    localparam int CHUNK   = 16;
    localparam int CHUNK_W = 4;
    // slot position width, enough for any reachable slot and for the count
    localparam int POS_W   = 7;
    localparam int ROWN_W  = POS_W - CHUNK_W;

    localparam logic [POS_W-1:0] ACTIVE_RESET = 7'd64;

    typedef enum logic [2:0] {
        MODE_ALLOC      = 3'd0,
        MODE_FREE       = 3'd1,
        MODE_QUERY      = 3'd2,
        MODE_ITER_FIRST = 3'd3,
        MODE_ITER_NEXT  = 3'd4
    } mode_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0] mode;
        logic [5:0] slot_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  result_slot;
        logic [10:0] byte_offset;
        logic        is_allocated;
        logic        iter_done;
    } out_item_t;

    // request to the row scanner
    typedef struct packed {
        logic              find_free;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  count;
        logic [ROWN_W-1:0] row_num;
        logic [CHUNK-1:0]  word;
    } scan_req_t;

    // scanner answer
    typedef struct packed {
        logic               hit;
        logic [CHUNK_W-1:0] hit_bit;
        logic               more;
    } scan_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bsa_ram.sv =====
`default_nettype none

module bsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsa_scan.sv =====
`default_nettype none

module bsa_scan
    import bsa_pkg::*;
(
    input  wire scan_req_t req,
    output scan_rsp_t      rsp
);

    logic [CHUNK-1:0]  cand;
    logic [POS_W-1:0]  pos;
    logic [POS_W:0]    next_base;

    // candidate bits: wanted polarity and inside [start, count)
    always_comb
    begin
        for (int j = 0; j < CHUNK; j++)
        begin
            pos     = {req.row_num, CHUNK_W'(j)};
            cand[j] = (req.find_free ? ~req.word[j] : req.word[j])
                      && (pos >= req.start_pos) && (pos < req.count);
        end
    end

    // lowest candidate wins
    always_comb
    begin
        rsp.hit     = |cand;
        rsp.hit_bit = '0;
        for (int j = CHUNK - 1; j >= 0; j--)
        begin
            if (cand[j])
            begin
                rsp.hit_bit = CHUNK_W'(j);
            end
        end
        next_base = {({1'b0, req.row_num} + 1'b1), {CHUNK_W{1'b0}}};
        rsp.more  = next_base < {1'b0, req.count};
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_slot_allocator_core.sv =====
`default_nettype none

// first-fit slot allocator over a bitmap held in a small row ram of 16 slots
// a row. start is taken when busy is low. allocate and iterate read one row
// per cycle through the single read port and test it in one shared row
// scanner, and the result strobe done comes in the first cycle with busy
// low. free and query visit one row. out-of-range free/query, iterate next
// with an exhausted cursor, allocate or iterate with no active slots, and
// unknown modes answer on done in the very next cycle without going busy.
// done is high for exactly one cycle and cannot be held off by the receiver,
// so result must be captured when done is seen. the map needs no clearing
// pass: each row has a valid bit cleared by reset, and a row not yet written
// reads as all free. the user must write active_slots through
// cfg_we/cfg_wdata only while the block is idle; the block itself does not
// enforce this.
module bitmap_slot_allocator_core
    import bsa_pkg::*;
#(
    parameter int SLOTS      = 64,
    parameter int SLOT_BYTES = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire in_item_t          in_item,
    output logic                   busy,
    output logic                   done,
    output out_item_t              result,
    input  wire logic              cfg_we,
    input  wire logic [POS_W-1:0]  cfg_wdata
);

    localparam int ROWS = (SLOTS + CHUNK - 1) / CHUNK;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    // largest count the 7-bit register can reach on this map size
    localparam int CAP  = (SLOTS < 127) ? SLOTS : 127;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EVAL
    } state_t;

    state_t             state_reg,     state_next;
    logic               done_reg,      done_next;
    out_item_t          result_reg,    result_next;
    logic [POS_W-1:0]   cursor_reg,    cursor_next;
    logic [POS_W-1:0]   active_reg,    active_next;
    logic [ROWS-1:0]    row_valid_reg, row_valid_next;
    logic [2:0]         mode_reg,      mode_next;
    logic [5:0]         idx_reg,       idx_next;
    logic [POS_W-1:0]   start_reg,     start_next;
    logic [ROWN_W-1:0]  row_num_reg,   row_num_next;

    logic [POS_W-1:0]   count;
    logic [POS_W-1:0]   idx_pos;
    logic [POS_W-1:0]   next_pos;
    logic [POS_W-1:0]   hit_pos;
    logic [10:0]        hit_offset;
    logic [CHUNK-1:0]   word;
    logic [CHUNK-1:0]   rdata;
    logic [CHUNK-1:0]   bit_mask;
    logic [CHUNK-1:0]   hit_mask;
    logic [AW-1:0]      row_addr;
    logic               ram_we;
    logic [CHUNK-1:0]   ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    scan_req_t          sreq;
    scan_rsp_t          srsp;

    // slots actually managed: min(active_slots, SLOTS, 127)
    assign count    = (active_reg > POS_W'(CAP)) ? POS_W'(CAP) : active_reg;
    assign idx_pos  = {1'b0, in_item.slot_index};
    assign next_pos = cursor_reg + 1'b1;

    // row ram: one read port walks rows, one write port updates a row
    assign row_addr  = AW'(row_num_reg);
    assign ram_re    = (state_reg == S_RD) || (state_reg == S_EVAL);
    // in the scan cycle the next row is fetched ahead in case the scan goes on
    assign ram_raddr = (state_reg == S_RD) ? row_addr : AW'(row_num_reg + 1'b1);

    bsa_ram #(
        .WIDTH (CHUNK),
        .DEPTH (ROWS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // a row never written holds only free slots
    assign word = row_valid_reg[row_addr] ? rdata : '0;

    assign sreq.find_free = (mode_reg == MODE_ALLOC);
    assign sreq.start_pos = start_reg;
    assign sreq.count     = count;
    assign sreq.row_num   = row_num_reg;
    assign sreq.word      = word;

    bsa_scan u_scan (
        .req (sreq),
        .rsp (srsp)
    );

    assign bit_mask   = CHUNK'(1) << idx_reg[CHUNK_W-1:0];
    assign hit_mask   = CHUNK'(1) << srsp.hit_bit;
    assign hit_pos    = {row_num_reg, srsp.hit_bit};
    assign hit_offset = 11'(32'(hit_pos) * 32'(SLOT_BYTES));

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        cursor_next    = cursor_reg;
        active_next    = active_reg;
        row_valid_next = row_valid_reg;
        mode_next      = mode_reg;
        idx_next       = idx_reg;
        start_next     = start_reg;
        row_num_next   = row_num_reg;
        ram_we         = 1'b0;
        ram_wdata      = word;

        if (cfg_we)
        begin
            active_next = cfg_wdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next   = in_item.mode;
                    idx_next    = in_item.slot_index;
                    start_next  = '0;
                    result_next = '0;
                    case (in_item.mode)
                        MODE_ALLOC,
                        MODE_ITER_FIRST:
                        begin
                            row_num_next = '0;
                            if (count == '0)
                            begin
                                // nothing managed: full, or iteration over at once
                                result_next.status = ST_NONE;
                                if (in_item.mode == MODE_ITER_FIRST)
                                begin
                                    result_next.iter_done = 1'b1;
                                    cursor_next           = count;
                                end
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        MODE_FREE,
                        MODE_QUERY:
                        begin
                            row_num_next = idx_pos[POS_W-1:CHUNK_W];
                            if (idx_pos >= count)
                            begin
                                result_next.status = ST_RANGE;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        MODE_ITER_NEXT:
                        begin
                            start_next   = next_pos;
                            row_num_next = next_pos[POS_W-1:CHUNK_W];
                            // cursor parked or on the last slot: nothing left
                            if ((cursor_reg >= count) || (next_pos >= count))
                            begin
                                result_next.status    = ST_NONE;
                                result_next.iter_done = 1'b1;
                                cursor_next           = count;
                                done_next             = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            // unknown mode: all-zero result, no change
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                case (mode_reg)
                    MODE_FREE:
                    begin
                        ram_we                   = 1'b1;
                        ram_wdata                = word & ~bit_mask;
                        row_valid_next[row_addr] = 1'b1;
                        state_next               = S_IDLE;
                        done_next                = 1'b1;
                    end
                    MODE_QUERY:
                    begin
                        result_next.is_allocated = |(word & bit_mask);
                        state_next               = S_IDLE;
                        done_next                = 1'b1;
                    end
                    default:
                    begin
                        // allocate and both iterate modes share the row scan
                        if (srsp.hit)
                        begin
                            result_next.result_slot = hit_pos[5:0];
                            result_next.byte_offset = hit_offset;
                            if (mode_reg == MODE_ALLOC)
                            begin
                                ram_we                   = 1'b1;
                                ram_wdata                = word | hit_mask;
                                row_valid_next[row_addr] = 1'b1;
                            end
                            else
                            begin
                                cursor_next = hit_pos;
                            end
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                        else if (srsp.more)
                        begin
                            // next row was fetched this cycle
                            row_num_next = row_num_reg + 1'b1;
                        end
                        else
                        begin
                            result_next.status = ST_NONE;
                            if (mode_reg != MODE_ALLOC)
                            begin
                                result_next.iter_done = 1'b1;
                                cursor_next           = count;
                            end
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            result_reg    <= '0;
            cursor_reg    <= '0;
            active_reg    <= ACTIVE_RESET;
            row_valid_reg <= '0;
            mode_reg      <= '0;
            idx_reg       <= '0;
            start_reg     <= '0;
            row_num_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
            cursor_reg    <= cursor_next;
            active_reg    <= active_next;
            row_valid_reg <= row_valid_next;
            mode_reg      <= mode_next;
            idx_reg       <= idx_next;
            start_reg     <= start_next;
            row_num_reg   <= row_num_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // results only leave once the sequencer is back at rest
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobe while busy");

    // end of iteration always comes with the not-found status
    a_iter_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.iter_done) |-> (result.status == ST_NONE))
        else $error("iteration done without not-found status");

    // a query hit is never an error result
    a_query_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_allocated) |-> (result.status == ST_OK))
        else $error("query answer on an error result");

    // a range error carries no slot
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_RANGE))
            |-> ((result.result_slot == '0) && (result.byte_offset == '0)))
        else $error("range error with slot data");

endmodule

`default_nettype wire
